>>> hdl/cle_pkg.sv
// shared types, key codes and event codes of the console line editor
// no dependencies; compiled first
package cle_pkg;

    localparam int DEF_BUFFER_DEPTH = 128;

    // key codes with a meaning of their own
    localparam logic [7:0] KEY_NUL     = 8'h00;
    localparam logic [7:0] KEY_EOT     = 8'h04;
    localparam logic [7:0] KEY_BS      = 8'h08;
    localparam logic [7:0] KEY_TAB     = 8'h09;
    localparam logic [7:0] KEY_LF      = 8'h0A;
    localparam logic [7:0] KEY_WLEFT   = 8'h0B;
    localparam logic [7:0] KEY_WRIGHT  = 8'h0C;
    localparam logic [7:0] KEY_CR      = 8'h0D;
    localparam logic [7:0] KEY_LIST    = 8'h10;
    localparam logic [7:0] KEY_KILL    = 8'h15;
    localparam logic [7:0] KEY_DEL     = 8'h7F;
    localparam logic [7:0] KEY_LEFT    = 8'hE4;
    localparam logic [7:0] KEY_RIGHT   = 8'hE5;

    // word delimiters
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [3:0] {
        EV_ECHO   = 4'd0,
        EV_ERASE  = 4'd1,
        EV_LEFT   = 4'd2,
        EV_RIGHT  = 4'd3,
        EV_WLEFT  = 4'd4,
        EV_WRIGHT = 4'd5,
        EV_READ   = 4'd6,
        EV_EMPTY  = 4'd7,
        EV_LIST   = 4'd8
    } t_kind;

    // class of the latched input beat
    typedef enum logic [3:0] {
        KC_READ, KC_LIST, KC_KILL, KC_BS, KC_ERALL, KC_LEFT, KC_RIGHT,
        KC_WLEFT, KC_WRIGHT, KC_INS_LINE, KC_INS, KC_NONE
    } t_kcls;

    // datapath micro-operations
    typedef enum logic [4:0] {
        UOP_NOP, UOP_LATCH, UOP_POP, UOP_OFF_INC, UOP_OFF_DEC, UOP_KILL_JUMP,
        UOP_CNT_CLR, UOP_RD_EDM1, UOP_KILL_STEP, UOP_ER_SETUP, UOP_SHL_RD,
        UOP_SHL_WR, UOP_ED_SUB, UOP_WL_RD, UOP_CNT_INC, UOP_WL_HIT, UOP_WR_RD,
        UOP_WR_HIT_D, UOP_WR_HIT_E, UOP_SHR_RD, UOP_SHR_WR, UOP_INS,
        UOP_INS_END, UOP_COMMIT
    } t_uop;

    typedef struct packed {
        logic operation;
        logic [7:0] key_code;
    } t_in_beat;

    typedef struct packed {
        logic [3:0] event_kind;
        logic [7:0] char_value;
        logic [7:0] move_count;
        logic [7:0] cursor_back;
        logic       line_ready;
        logic       last_event;
    } t_out_beat;

    typedef struct packed {
        t_uop  uop;
        logic  emit;
        t_kind kind;
        logic  last;
    } t_cmd;

    typedef struct packed {
        t_kcls kcls;
        logic  full;
        logic  rd_eq_cm;
        logic  left_zero;
        logic  off_zero;
        logic  off_lt2;
        logic  ed_eq_cm;
        logic  cnt_eq_depth;
        logic  cnt_zero;
        logic  j_eq_off;
        logic  cnt_eq_leftm1;
        logic  cnt_eq_offm2;
        logic  q_newline;
        logic  q_delim;
        logic  out_free;
    } t_sts;

    function automatic logic is_delim(input logic [7:0] c);
        return (c == CH_DOT) || (c == CH_COMMA) || (c == CH_SEMI) ||
               (c == CH_COLON) || (c == CH_SPACE);
    endfunction

endpackage

>>> hdl/cle_chan_if.sv
// valid/ready channel carrying one payload beat
// payload type given by the instantiating level
interface cle_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/cle_ctrl.sv
// sequencer of the line editor: walks each beat through datapath micro-operations
// depends on cle_pkg
module cle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cle_pkg::t_sts i_sts,
    output cle_pkg::t_cmd o_cmd
);
    import cle_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_KCHK, S_KTST, S_KEND, S_ECHK, S_SHL, S_SHLW,
        S_WL, S_WLT, S_WR, S_WRT, S_SHR, S_SHRW, S_COMMIT, S_EMIT
    } t_state;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;
    logic   r_last, n_last;
    logic   r_kj, n_kj;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and command
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_last     = r_last;
        n_kj       = r_kj;
        o_cmd.uop  = UOP_NOP;
        o_cmd.emit = 1'b0;
        o_cmd.kind = r_kind;
        o_cmd.last = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.uop = UOP_LATCH;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                n_last  = 1'b1;
                n_state = S_IDLE;
                unique case (i_sts.kcls)
                    KC_READ: begin
                        n_state = S_EMIT;
                        if (i_sts.rd_eq_cm) begin
                            n_kind = EV_EMPTY;
                        end else begin
                            o_cmd.uop = UOP_POP;
                            n_kind    = EV_READ;
                        end
                    end
                    KC_LIST: begin
                        n_kind  = EV_LIST;
                        n_state = S_EMIT;
                    end
                    KC_LEFT: begin
                        if (!i_sts.left_zero) begin
                            o_cmd.uop = UOP_OFF_INC;
                            n_kind    = EV_LEFT;
                            n_state   = S_EMIT;
                        end
                    end
                    KC_RIGHT: begin
                        if (!i_sts.off_zero) begin
                            o_cmd.uop = UOP_OFF_DEC;
                            n_kind    = EV_RIGHT;
                            n_state   = S_EMIT;
                        end
                    end
                    KC_KILL: begin
                        n_kj      = !i_sts.off_zero;
                        o_cmd.uop = i_sts.off_zero ? UOP_CNT_CLR : UOP_KILL_JUMP;
                        n_state   = S_KCHK;
                    end
                    KC_BS, KC_ERALL: begin
                        o_cmd.uop = UOP_ER_SETUP;
                        n_state   = S_ECHK;
                    end
                    KC_WLEFT: begin
                        if (!i_sts.left_zero) begin
                            o_cmd.uop = UOP_CNT_CLR;
                            n_state   = S_WL;
                        end
                    end
                    KC_WRIGHT: begin
                        if (!i_sts.off_lt2) begin
                            o_cmd.uop = UOP_CNT_CLR;
                            n_state   = S_WR;
                        end
                    end
                    KC_INS_LINE: begin
                        if (!i_sts.full) begin
                            o_cmd.uop = UOP_INS_END;
                            n_state   = S_COMMIT;
                        end
                    end
                    KC_INS: begin
                        if (!i_sts.full) begin
                            o_cmd.uop = UOP_CNT_CLR;
                            n_state   = S_SHR;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            // kill line: walk back to the last newline
            S_KCHK: begin
                if (i_sts.ed_eq_cm || i_sts.cnt_eq_depth) begin
                    n_state = S_KEND;
                end else begin
                    o_cmd.uop = UOP_RD_EDM1;
                    n_state   = S_KTST;
                end
            end
            S_KTST: begin
                if (i_sts.q_newline) begin
                    n_state = S_KEND;
                end else begin
                    o_cmd.uop = UOP_KILL_STEP;
                    n_state   = S_KCHK;
                end
            end
            S_KEND: begin
                if (r_kj) begin
                    n_kind  = EV_WRIGHT;
                    n_last  = i_sts.cnt_zero;
                    n_state = S_EMIT;
                end else if (!i_sts.cnt_zero) begin
                    n_kind  = EV_ERASE;
                    n_last  = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // erase: shift the text right of the cursor left
            S_ECHK: begin
                n_state = i_sts.cnt_zero ? S_IDLE : S_SHL;
            end
            S_SHL: begin
                if (i_sts.j_eq_off) begin
                    o_cmd.uop = UOP_ED_SUB;
                    n_kind    = EV_ERASE;
                    n_state   = S_EMIT;
                end else begin
                    o_cmd.uop = UOP_SHL_RD;
                    n_state   = S_SHLW;
                end
            end
            S_SHLW: begin
                o_cmd.uop = UOP_SHL_WR;
                n_state   = S_SHL;
            end
            // word left scan
            S_WL: begin
                if (i_sts.cnt_eq_leftm1) begin
                    o_cmd.uop = UOP_WL_HIT;
                    n_kind    = EV_WLEFT;
                    n_state   = S_EMIT;
                end else begin
                    o_cmd.uop = UOP_WL_RD;
                    n_state   = S_WLT;
                end
            end
            S_WLT: begin
                if (i_sts.q_delim) begin
                    o_cmd.uop = UOP_WL_HIT;
                    n_kind    = EV_WLEFT;
                    n_state   = S_EMIT;
                end else begin
                    o_cmd.uop = UOP_CNT_INC;
                    n_state   = S_WL;
                end
            end
            // word right scan
            S_WR: begin
                o_cmd.uop = UOP_WR_RD;
                n_state   = S_WRT;
            end
            S_WRT: begin
                if (i_sts.q_delim) begin
                    o_cmd.uop = UOP_WR_HIT_D;
                    n_kind    = EV_WRIGHT;
                    n_state   = S_EMIT;
                end else if (i_sts.cnt_eq_offm2) begin
                    o_cmd.uop = UOP_WR_HIT_E;
                    n_kind    = EV_WRIGHT;
                    n_state   = S_EMIT;
                end else begin
                    o_cmd.uop = UOP_CNT_INC;
                    n_state   = S_WR;
                end
            end
            // insert: open a gap at the cursor
            S_SHR: begin
                if (i_sts.j_eq_off) begin
                    o_cmd.uop = UOP_INS;
                    n_state   = S_COMMIT;
                end else begin
                    o_cmd.uop = UOP_SHR_RD;
                    n_state   = S_SHRW;
                end
            end
            S_SHRW: begin
                o_cmd.uop = UOP_SHR_WR;
                n_state   = S_SHR;
            end
            S_COMMIT: begin
                o_cmd.uop = UOP_COMMIT;
                n_kind    = EV_ECHO;
                n_state   = S_EMIT;
            end
            // hand a result beat to the output register
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_kind = EV_ERASE;
                        n_last = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= EV_ECHO;
            r_last  <= 1'b1;
            r_kj    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_last  <= n_last;
            r_kj    <= n_kj;
        end
    end

endmodule

>>> hdl/cle_dp.sv
// datapath of the line editor: ring indices, line memory, scan counters, output register
// depends on cle_pkg
module cle_dp #(
    parameter int BUFFER_DEPTH = cle_pkg::DEF_BUFFER_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cle_pkg::t_cmd     i_cmd,
    output cle_pkg::t_sts     o_sts,
    input  cle_pkg::t_in_beat i_beat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output cle_pkg::t_out_beat o_out_beat
);
    import cle_pkg::*;

    localparam int IW  = $clog2(2 * BUFFER_DEPTH);
    localparam int IW1 = IW + 1;
    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam logic [IW:0]   SPAN  = IW1'(2 * BUFFER_DEPTH);
    localparam logic [IW-1:0] DEPTH = IW'(BUFFER_DEPTH);

    function automatic logic [IW-1:0] wadd(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SPAN) s = s - SPAN;
        return s[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] wsub(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW:0] s;
        if (a >= b) s = {1'b0, a} - {1'b0, b};
        else        s = {1'b0, a} + SPAN - {1'b0, b};
        return s[IW-1:0];
    endfunction

    function automatic logic [AW-1:0] slot(input logic [IW-1:0] p);
        logic [IW-1:0] s;
        s = (p >= DEPTH) ? p - DEPTH : p;
        return s[AW-1:0];
    endfunction

    function automatic logic [7:0] low8(input logic [IW-1:0] v);
        logic [IW+7:0] w;
        w = {8'd0, v};
        return w[7:0];
    endfunction

    logic            r_op, n_op;
    logic [7:0]      r_key, n_key;
    logic [IW-1:0]   r_rd, n_rd, r_cm, n_cm, r_ed, n_ed;
    logic [IW-1:0]   r_off, n_off, r_jump, n_jump, r_cnt, n_cnt, r_j, n_j;
    logic            r_rdy, n_rdy;
    logic [7:0]      r_q;
    logic [7:0]      r_mem [BUFFER_DEPTH];
    logic            r_ovalid;
    t_out_beat       r_out, n_out;

    logic            mem_re, mem_we;
    logic [AW-1:0]   mem_ra, mem_wa;
    logic [7:0]      mem_wd;

    logic [IW-1:0]   linelen, left, cur, used, er_cnt;
    logic [7:0]      ch;
    t_kcls           kcls;
    logic            out_free;

    // line geometry
    assign linelen  = wsub(r_ed, r_cm);
    assign left     = (linelen >= r_off) ? linelen - r_off : '0;
    assign cur      = wsub(r_ed, r_off);
    assign used     = wsub(r_ed, r_rd);
    assign ch       = (r_key == KEY_CR) ? KEY_LF : r_key;
    assign out_free = !r_ovalid || i_out_ready;

    // key class
    always_comb begin
        if (r_op == OP_READ) begin
            kcls = KC_READ;
        end else begin
            unique case (r_key) inside
                KEY_LIST:                 kcls = KC_LIST;
                KEY_KILL:                 kcls = KC_KILL;
                KEY_BS, KEY_DEL:          kcls = KC_BS;
                KEY_TAB:                  kcls = KC_ERALL;
                KEY_LEFT:                 kcls = KC_LEFT;
                KEY_RIGHT:                kcls = KC_RIGHT;
                KEY_WLEFT:                kcls = KC_WLEFT;
                KEY_WRIGHT:               kcls = KC_WRIGHT;
                KEY_NUL:                  kcls = KC_NONE;
                KEY_LF, KEY_CR, KEY_EOT:  kcls = KC_INS_LINE;
                default:                  kcls = KC_INS;
            endcase
        end
    end

    // characters to erase
    always_comb begin
        if (kcls == KC_ERALL) er_cnt = (left > DEPTH) ? DEPTH : left;
        else                  er_cnt = (left != '0) ? IW'(1) : '0;
    end

    // status to the sequencer
    always_comb begin
        o_sts.kcls          = kcls;
        o_sts.full          = (used >= DEPTH);
        o_sts.rd_eq_cm      = (r_rd == r_cm);
        o_sts.left_zero     = (left == '0);
        o_sts.off_zero      = (r_off == '0);
        o_sts.off_lt2       = (r_off < IW'(2));
        o_sts.ed_eq_cm      = (r_ed == r_cm);
        o_sts.cnt_eq_depth  = (r_cnt == DEPTH);
        o_sts.cnt_zero      = (r_cnt == '0);
        o_sts.j_eq_off      = (r_j == r_off);
        o_sts.cnt_eq_leftm1 = (r_cnt + IW'(1) == left);
        o_sts.cnt_eq_offm2  = (r_cnt + IW'(2) == r_off);
        o_sts.q_newline     = (r_q == KEY_LF);
        o_sts.q_delim       = is_delim(r_q);
        o_sts.out_free      = out_free;
    end

    // micro-operation decode
    always_comb begin
        n_op   = r_op;
        n_key  = r_key;
        n_rd   = r_rd;
        n_cm   = r_cm;
        n_ed   = r_ed;
        n_off  = r_off;
        n_jump = r_jump;
        n_cnt  = r_cnt;
        n_j    = r_j;
        n_rdy  = r_rdy;
        mem_re = 1'b0;
        mem_we = 1'b0;
        mem_ra = slot(r_rd);
        mem_wa = slot(r_ed);
        mem_wd = r_q;
        unique case (i_cmd.uop)
            UOP_NOP: ;
            UOP_LATCH: begin
                n_op  = i_beat.operation;
                n_key = i_beat.key_code;
            end
            UOP_POP: begin
                mem_re = 1'b1;
                mem_ra = slot(r_rd);
                n_rd   = wadd(r_rd, IW'(1));
            end
            UOP_OFF_INC: n_off = r_off + IW'(1);
            UOP_OFF_DEC: n_off = r_off - IW'(1);
            UOP_KILL_JUMP: begin
                n_jump = r_off;
                n_off  = '0;
                n_cnt  = '0;
            end
            UOP_CNT_CLR: begin
                n_cnt = '0;
                n_j   = '0;
            end
            UOP_RD_EDM1: begin
                mem_re = 1'b1;
                mem_ra = slot(wsub(r_ed, IW'(1)));
            end
            UOP_KILL_STEP: begin
                n_ed  = wsub(r_ed, IW'(1));
                n_cnt = r_cnt + IW'(1);
            end
            UOP_ER_SETUP: begin
                n_cnt = er_cnt;
                n_j   = '0;
            end
            UOP_SHL_RD: begin
                mem_re = 1'b1;
                mem_ra = slot(wadd(cur, r_j));
            end
            UOP_SHL_WR: begin
                mem_we = 1'b1;
                mem_wa = slot(wsub(wadd(cur, r_j), r_cnt));
                n_j    = r_j + IW'(1);
            end
            UOP_ED_SUB: n_ed = wsub(r_ed, r_cnt);
            UOP_WL_RD: begin
                mem_re = 1'b1;
                mem_ra = slot(wsub(cur, r_cnt + IW'(2)));
            end
            UOP_CNT_INC: n_cnt = r_cnt + IW'(1);
            UOP_WL_HIT: begin
                n_jump = r_cnt + IW'(1);
                n_off  = r_off + r_cnt + IW'(1);
            end
            UOP_WR_RD: begin
                mem_re = 1'b1;
                mem_ra = slot(wadd(cur, r_cnt + IW'(1)));
            end
            UOP_WR_HIT_D: begin
                n_jump = r_cnt + IW'(1);
                n_off  = r_off - r_cnt - IW'(1);
            end
            UOP_WR_HIT_E: begin
                n_jump = r_cnt + IW'(2);
                n_off  = r_off - r_cnt - IW'(2);
            end
            UOP_SHR_RD: begin
                mem_re = 1'b1;
                mem_ra = slot(wsub(r_ed, r_j + IW'(1)));
            end
            UOP_SHR_WR: begin
                mem_we = 1'b1;
                mem_wa = slot(wsub(r_ed, r_j));
                n_j    = r_j + IW'(1);
            end
            UOP_INS: begin
                mem_we = 1'b1;
                mem_wa = slot(cur);
                mem_wd = ch;
                n_ed   = wadd(r_ed, IW'(1));
            end
            UOP_INS_END: begin
                mem_we = 1'b1;
                mem_wa = slot(r_ed);
                mem_wd = ch;
                n_ed   = wadd(r_ed, IW'(1));
            end
            UOP_COMMIT: begin
                if (kcls == KC_INS_LINE || used == DEPTH) begin
                    n_off = '0;
                    n_cm  = r_ed;
                    n_rdy = 1'b1;
                end else begin
                    n_rdy = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // result beat
    always_comb begin
        n_out.event_kind  = i_cmd.kind;
        n_out.char_value  = 8'd0;
        n_out.move_count  = 8'd0;
        n_out.cursor_back = low8(r_off);
        n_out.line_ready  = 1'b0;
        n_out.last_event  = i_cmd.last;
        case (i_cmd.kind)
            EV_ECHO: begin
                n_out.char_value = ch;
                n_out.line_ready = r_rdy;
            end
            EV_READ:             n_out.char_value = r_q;
            EV_ERASE:            n_out.move_count = low8(r_cnt);
            EV_WLEFT, EV_WRIGHT: n_out.move_count = low8(r_jump);
            default: ;
        endcase
    end

    // line memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_q <= r_mem[mem_ra];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) r_out <= n_out;
    end

    // index and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= OP_KEY;
            r_key    <= KEY_NUL;
            r_rd     <= '0;
            r_cm     <= '0;
            r_ed     <= '0;
            r_off    <= '0;
            r_jump   <= '0;
            r_cnt    <= '0;
            r_j      <= '0;
            r_rdy    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_op   <= n_op;
            r_key  <= n_key;
            r_rd   <= n_rd;
            r_cm   <= n_cm;
            r_ed   <= n_ed;
            r_off  <= n_off;
            r_jump <= n_jump;
            r_cnt  <= n_cnt;
            r_j    <= n_j;
            r_rdy  <= n_rdy;
            if (i_cmd.emit)       r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_beat  = r_out;

`ifndef ASSERT_OFF
    a_cursor_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off <= linelen) else $error("cursor left of the line start");
    a_ring_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used <= DEPTH) else $error("ring holds more than its depth");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free) else $error("result overwrites a pending beat");
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_ovalid) else $error("emitted result not presented");
`endif

endmodule

>>> hdl/console_line_editor_core.sv
// top level of the console line editor: sequencer plus datapath
// depends on cle_pkg, cle_chan_if, cle_ctrl, cle_dp
//
// Keyboard line editor over a ring of BUFFER_DEPTH bytes. Each input beat is a
// keystroke or a read request; it yields zero, one or two result beats, the last
// one flagged by last_event. One beat is worked at a time, all through a single
// port line memory with registered read data. Reads, list and single cursor
// moves go straight from decode to the result; insert and erase move each
// character right of the cursor with one read and one write; word moves and
// kill line read and test each character scanned. The result sits in an
// output register, so the next beat is taken while a result still waits. No
// clearing pass after reset.
module console_line_editor_core #(
    parameter int BUFFER_DEPTH = cle_pkg::DEF_BUFFER_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cle_chan_if.sink   i_in,
    cle_chan_if.source o_out
);
    import cle_pkg::*;

    t_cmd      cmd;
    t_sts      sts;
    t_in_beat  in_beat;
    t_out_beat out_beat;
    logic      out_valid;
    logic      in_ready;

    assign in_beat    = i_in.data;
    assign i_in.ready = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_beat;

    // sequencer
    cle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    cle_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_beat      (in_beat),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_out_beat  (out_beat)
    );

endmodule

>>> tb/console_line_editor_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of console_line_editor_core: own editor model, random traffic
// depends on cle_pkg, cle_chan_if and the rtl of console_line_editor_core
module console_line_editor_core_tb;
    import cle_pkg::*;

    logic i_clk;
    logic i_rst_n;

    cle_chan_if #(.T(t_in_beat))  key_ch ();
    cle_chan_if #(.T(t_out_beat)) evt_ch ();

    console_line_editor_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (key_ch.sink),
        .o_out   (evt_ch.source)
    );

    // editor model state
    logic [7:0] ring_q [128];
    logic [7:0] rd_ix, cm_ix, ed_ix, back_off, jump_len;

    t_in_beat  pending_keys [$];
    t_out_beat expected_events [$];
    int        err_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        key_taken;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic bit word_break(input logic [7:0] c);
        return c == 8'h2E || c == 8'h2C || c == 8'h3B || c == 8'h3A || c == 8'h20;
    endfunction

    // work out the events of one accepted beat and queue them
    task automatic predict_editor(input t_in_beat b);
        t_out_beat  ev [2];
        int         nev;
        logic [7:0] linelen, lft, cur, t, c, u;
        int         n, i, j, cnt;
        bit         ready;
        nev = 0;
        linelen = ed_ix - cm_ix;
        lft = (linelen >= back_off) ? linelen - back_off : 8'd0;
        cur = ed_ix - back_off;
        for (i = 0; i < 2; i++) ev[i] = '0;
        if (b.operation == OP_READ) begin
            if (rd_ix != cm_ix) begin
                ev[0].event_kind = EV_READ;
                ev[0].char_value = ring_q[rd_ix[6:0]];
                rd_ix++;
            end else begin
                ev[0].event_kind = EV_EMPTY;
            end
            nev = 1;
        end else if (b.key_code == KEY_LIST) begin
            ev[0].event_kind = EV_LIST;
            nev = 1;
        end else if (b.key_code == KEY_KILL) begin
            if (back_off != 0) begin
                jump_len = back_off;
                back_off = 0;
                ev[0].event_kind = EV_WRIGHT;
                ev[0].move_count = jump_len;
                nev = 1;
            end
            n = 0;
            while (ed_ix != cm_ix && n < 128) begin
                t = ed_ix - 8'd1;
                if (ring_q[t[6:0]] == KEY_LF) break;
                ed_ix--;
                n++;
            end
            if (n != 0) begin
                ev[nev].event_kind = EV_ERASE;
                ev[nev].move_count = n[7:0];
                nev++;
            end
        end else if (b.key_code == KEY_BS || b.key_code == KEY_DEL
                     || b.key_code == KEY_TAB) begin
            n = (b.key_code == KEY_TAB) ? int'(lft) : 1;
            cnt = 0;
            for (i = 0; i < n; i++) begin
                t = ed_ix - back_off;
                if (t == cm_ix) break;
                for (j = 0; j < back_off; j++) begin
                    c = t + j[7:0];
                    u = c - 8'd1;
                    ring_q[u[6:0]] = ring_q[c[6:0]];
                end
                ed_ix--;
                cnt++;
            end
            if (cnt != 0) begin
                ev[0].event_kind = EV_ERASE;
                ev[0].move_count = cnt[7:0];
                nev = 1;
            end
        end else if (b.key_code == KEY_LEFT) begin
            if (lft > 0) begin
                back_off++;
                ev[0].event_kind = EV_LEFT;
                nev = 1;
            end
        end else if (b.key_code == KEY_RIGHT) begin
            if (back_off > 0) begin
                back_off--;
                ev[0].event_kind = EV_RIGHT;
                nev = 1;
            end
        end else if (b.key_code == KEY_WLEFT) begin
            for (n = 0; n < lft; n++) begin
                t = cur - n[7:0] - 8'd2;
                if (word_break(ring_q[t[6:0]]) || n == lft - 1) begin
                    jump_len = 8'(n + 1);
                    back_off += jump_len;
                    ev[0].event_kind = EV_WLEFT;
                    ev[0].move_count = jump_len;
                    nev = 1;
                    break;
                end
            end
        end else if (b.key_code == KEY_WRIGHT) begin
            for (n = 0; back_off >= 2 && n < back_off - 1; n++) begin
                t = cur + n[7:0] + 8'd1;
                if (word_break(ring_q[t[6:0]]) || n == back_off - 2) begin
                    jump_len = word_break(ring_q[t[6:0]]) ? 8'(n + 1) : 8'(n + 2);
                    back_off -= jump_len;
                    ev[0].event_kind = EV_WRIGHT;
                    ev[0].move_count = jump_len;
                    nev = 1;
                    break;
                end
            end
        end else if (b.key_code != KEY_NUL && (ed_ix - rd_ix) < 8'd128) begin
            c = (b.key_code == KEY_CR) ? KEY_LF : b.key_code;
            if (c == KEY_LF || c == KEY_EOT) begin
                ring_q[ed_ix[6:0]] = c;
            end else begin
                for (j = 0; j < back_off; j++) begin
                    t = ed_ix - j[7:0];
                    u = t - 8'd1;
                    ring_q[t[6:0]] = ring_q[u[6:0]];
                end
                ring_q[cur[6:0]] = c;
            end
            ed_ix++;
            ready = (c == KEY_LF || c == KEY_EOT || (ed_ix - rd_ix) == 8'd128);
            if (ready) begin
                back_off = 0;
                cm_ix = ed_ix;
            end
            ev[0].event_kind = EV_ECHO;
            ev[0].char_value = c;
            ev[0].line_ready = ready;
            nev = 1;
        end
        for (i = 0; i < nev; i++) begin
            ev[i].cursor_back = back_off;
            ev[i].last_event = (i == nev - 1);
            expected_events.push_back(ev[i]);
        end
    endtask

    function automatic t_in_beat random_key();
        t_in_beat b;
        int r;
        r = $urandom_range(0, 99);
        b.operation = OP_KEY;
        if (r < 20) begin
            b.operation = OP_READ;
            b.key_code = 8'($urandom);
        end else if (r < 40) begin
            case ($urandom_range(0, 11))
                0: b.key_code = KEY_LEFT;
                1: b.key_code = KEY_RIGHT;
                2: b.key_code = KEY_WLEFT;
                3: b.key_code = KEY_WRIGHT;
                4: b.key_code = KEY_BS;
                5: b.key_code = KEY_DEL;
                6: b.key_code = KEY_TAB;
                7: b.key_code = KEY_KILL;
                8: b.key_code = KEY_LIST;
                9: b.key_code = KEY_EOT;
                10: b.key_code = KEY_NUL;
                default: b.key_code = KEY_CR;
            endcase
        end else if (r < 46) begin
            b.key_code = 8'($urandom);
        end else if (r < 58) begin
            case ($urandom_range(0, 4))
                0: b.key_code = CH_DOT;
                1: b.key_code = CH_COMMA;
                2: b.key_code = CH_SEMI;
                3: b.key_code = CH_COLON;
                default: b.key_code = CH_SPACE;
            endcase
        end else begin
            b.key_code = 8'($urandom_range(8'h21, 8'h7E));
        end
        return b;
    endfunction

    // acceptance and check of result beats
    always @(posedge i_clk) begin
        if (i_rst_n && key_ch.valid && key_ch.ready) begin
            predict_editor(key_ch.data);
        end
        if (i_rst_n && evt_ch.valid && evt_ch.ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                t_out_beat e;
                e = expected_events.pop_front();
                if (evt_ch.data.event_kind != e.event_kind)
                    report_mismatch($sformatf("event_kind %0d, want %0d",
                        evt_ch.data.event_kind, e.event_kind));
                if (evt_ch.data.char_value != e.char_value)
                    report_mismatch($sformatf("char_value %h, want %h",
                        evt_ch.data.char_value, e.char_value));
                if (evt_ch.data.move_count != e.move_count)
                    report_mismatch($sformatf("move_count %0d, want %0d",
                        evt_ch.data.move_count, e.move_count));
                if (evt_ch.data.cursor_back != e.cursor_back)
                    report_mismatch($sformatf("cursor_back %0d, want %0d",
                        evt_ch.data.cursor_back, e.cursor_back));
                if (evt_ch.data.line_ready != e.line_ready)
                    report_mismatch($sformatf("line_ready %b, want %b",
                        evt_ch.data.line_ready, e.line_ready));
                if (evt_ch.data.last_event != e.last_event)
                    report_mismatch($sformatf("last_event %b, want %b",
                        evt_ch.data.last_event, e.last_event));
            end
        end
    end

    // remember whether the key beat was taken at the last rising edge
    always @(posedge i_clk) begin
        key_taken <= i_rst_n && key_ch.valid && key_ch.ready;
    end

    // key beat driver, fed from pending_keys
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            key_ch.valid <= 1'b0;
        end else if (!key_ch.valid || key_taken) begin
            if (pending_keys.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                key_ch.valid <= 1'b1;
                key_ch.data  <= pending_keys.pop_front();
            end else begin
                key_ch.valid <= 1'b0;
            end
        end
        evt_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // wait until every queued beat is sent and every result has come
    task automatic drain();
        while (pending_keys.size() != 0 || key_ch.valid || expected_events.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_in_beat b;
        logic [7:0] directed [];
        int i, ph;
        directed = '{8'h61, 8'h62, CH_SPACE, 8'h63, 8'h64, KEY_LEFT,
            KEY_LEFT, KEY_LEFT, KEY_WLEFT, KEY_WRIGHT, KEY_WRIGHT, KEY_RIGHT, KEY_LEFT,
            KEY_WRIGHT, 8'h78, KEY_TAB, KEY_BS, KEY_DEL, KEY_LEFT, KEY_KILL, KEY_LIST,
            KEY_NUL, 8'hFF, KEY_CR, 8'h40, KEY_EOT};
        err_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        rd_ix = 0; cm_ix = 0; ed_ix = 0; back_off = 0; jump_len = 0;
        for (i = 0; i < 128; i++) ring_q[i] = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill the whole ring so every slot holds a written byte; commits on full
        for (i = 0; i < 128; i++)
            pending_keys.push_back(t_in_beat'{OP_KEY, 8'(8'h41 + i % 26)});
        for (i = 0; i < 129; i++) pending_keys.push_back(t_in_beat'{OP_READ, 8'h00});
        // edits, moves at limits, kill with cursor inside, ignored keys, commits
        foreach (directed[k]) pending_keys.push_back(t_in_beat'{OP_KEY, directed[k]});
        for (i = 0; i < 6; i++) pending_keys.push_back(t_in_beat'{OP_READ, 8'hFF});
        drain();

        // random traffic in three idling phases
        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct  = (ph == 0) ? 14 : (ph == 1) ? 47 : 0;
            recv_stall_pct = (ph == 0) ? 47 : (ph == 1) ? 14 : 0;
            for (i = 0; i < 155; i++) begin
                b = random_key();
                pending_keys.push_back(b);
            end
            drain();
        end
        repeat (600) @(posedge i_clk);
        if (err_count == 0 && expected_events.size() == 0) begin
            $display("console_line_editor_core regression: pass");
        end else begin
            $display("console_line_editor_core regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #30ms;
        $display("console_line_editor_core regression: fail");
        $finish;
    end
endmodule
